/* rtl/record_family_reassembler_unit_assert.svh */
// ----------------------------------------------------------------------------
// Record family reassembler assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECORD_FAMILY_REASSEMBLER_UNIT_ASSERT_SVH
`define RECORD_FAMILY_REASSEMBLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define RFR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define RFR_ASSERT(label, prop, msg)
`define RFR_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

/* rtl/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// Record family reassembler package
// Shared types and fixed constants for the reassembler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfr_pkg;

    localparam int SEQ_W        = 32;
    localparam int PROV_W       = 303;
    localparam int SLOT_FULL_W  = 7;
    localparam int SLOT_OUT_W   = 5;
    localparam int S_TDATA_W    = 344;
    localparam int M_TDATA_W    = 40;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic OP_CHUNK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_STALE      = 2'd1,
        ERR_PROVENANCE = 2'd2,
        ERR_DUPLICATE  = 2'd3
    } err_t;

    typedef struct packed {
        logic                   clear;
        logic [SEQ_W-1:0]       seq;
        logic [SLOT_FULL_W-1:0] slot;
        logic                   in_range;
        logic [PROV_W-1:0]      prov;
    } item_t;

endpackage

/* rtl/rfr_front.sv */
// ----------------------------------------------------------------------------
// Reassembler front end
// Accepts chunk and clear items, unpacks fields, computes slot and range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfr_front #(
    parameter int CHANNELS           = 7,
    parameter int CHUNKS_PER_CHANNEL = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sequence_req, channel, chunk_index, generation, sample_rate, sample_total,
    // lane_and_status, first_index, drop_counts, frequency_mhz, metadata_word
    input  logic [rfr_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           item_valid,
    input  logic                           item_ready,
    output rfr_pkg::item_t                 item
);

    logic           valid_reg;
    logic           valid_next;
    rfr_pkg::item_t item_reg;
    rfr_pkg::item_t item_next;
    logic [2:0]     channel;
    logic [1:0]     chunk_index;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    assign channel     = s_tdata[34:32];
    assign chunk_index = s_tdata[36:35];

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
        item_next.clear    = (s_tuser == rfr_pkg::OP_CLEAR);
        item_next.seq      = s_tdata[31:0];
        item_next.slot     = rfr_pkg::SLOT_FULL_W'(channel)
                           * rfr_pkg::SLOT_FULL_W'(CHUNKS_PER_CHANNEL)
                           + rfr_pkg::SLOT_FULL_W'(chunk_index);
        item_next.in_range = ({1'b0, channel} < 4'(CHANNELS))
                          && ({3'b000, chunk_index} < 5'(CHUNKS_PER_CHANNEL));
        // generation through metadata_word, bits 339..37 of s_tdata
        item_next.prov     = s_tdata[339:37];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/rfr_queue.sv */
// ----------------------------------------------------------------------------
// Reassembler item queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rfr_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rfr_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfr_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/rfr_back.sv */
// ----------------------------------------------------------------------------
// Reassembler back end
// Holds family state, checks sequence/provenance/slot, drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "record_family_reassembler_unit_assert.svh"

module rfr_back #(
    parameter int CHANNELS           = 7,
    parameter int CHUNKS_PER_CHANNEL = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  rfr_pkg::item_t                item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // record_slot, family_started, completed, lost_families
    output logic [rfr_pkg::M_TDATA_W-1:0] m_tdata,
    // error_code
    output logic [1:0]                    m_tuser
);

    localparam int SLOT_COUNT = CHANNELS * CHUNKS_PER_CHANNEL;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TOTAL_W    = $clog2(SLOT_COUNT + 1);
    localparam int SEQ_W      = rfr_pkg::SEQ_W;

    logic                       partial_open_reg, partial_open_next;
    logic [SEQ_W-1:0]           partial_seq_reg, partial_seq_next;
    logic [rfr_pkg::PROV_W-1:0] partial_prov_reg, partial_prov_next;
    logic [SLOT_COUNT-1:0]      received_map_reg, received_map_next;
    logic [TOTAL_W-1:0]         received_total_reg, received_total_next;
    logic                       last_valid_reg, last_valid_next;
    logic [SEQ_W-1:0]           last_seq_reg, last_seq_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [rfr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    rfr_pkg::err_t              err_reg, err_next;

    logic                       load;
    logic [SEQ_W-1:0]           diff_open;
    logic [SEQ_W-1:0]           diff_last;
    logic                       fwd_open;
    logic                       fwd_last;
    logic [SLOT_W-1:0]          idx;
    logic [SLOT_COUNT-1:0]      one_hot;
    logic [TOTAL_W-1:0]         total_inc;
    logic                       opens;
    logic                       done;
    logic [SEQ_W-1:0]           gap;
    rfr_pkg::err_t              err;

    assign item_ready = !m_tvalid_reg || m_tready;
    assign load       = item_valid && item_ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser    = err_reg;

    // forward means difference nonzero and below half the sequence space
    assign diff_open = item.seq - partial_seq_reg;
    assign diff_last = item.seq - last_seq_reg;
    assign fwd_open  = (diff_open != '0) && !diff_open[SEQ_W-1];
    assign fwd_last  = (diff_last != '0) && !diff_last[SEQ_W-1];
    assign idx       = item.slot[SLOT_W-1:0];

    always_comb
    begin
        one_hot      = '0;
        one_hot[idx] = 1'b1;
    end

    always_comb
    begin
        err   = rfr_pkg::ERR_OK;
        opens = 1'b0;
        gap   = '0;
        if (partial_open_reg && (item.seq != partial_seq_reg))
        begin
            if (!fwd_open)
            begin
                err = rfr_pkg::ERR_STALE;
            end
            else
            begin
                opens = 1'b1;
                gap   = diff_open;
            end
        end
        else if (!partial_open_reg)
        begin
            opens = 1'b1;
            if (last_valid_reg)
            begin
                if (!fwd_last)
                begin
                    err = rfr_pkg::ERR_STALE;
                end
                else
                begin
                    gap = diff_last - 1'b1;
                end
            end
        end
        if ((err == rfr_pkg::ERR_OK) && !opens && (item.prov != partial_prov_reg))
        begin
            err = rfr_pkg::ERR_PROVENANCE;
        end
        if (err == rfr_pkg::ERR_OK)
        begin
            if (!item.in_range || (!opens && received_map_reg[idx]))
            begin
                err = rfr_pkg::ERR_DUPLICATE;
            end
        end
    end

    assign total_inc = opens ? TOTAL_W'(1) : received_total_reg + 1'b1;
    assign done      = (total_inc == TOTAL_W'(SLOT_COUNT));

    always_comb
    begin
        partial_open_next   = partial_open_reg;
        partial_seq_next    = partial_seq_reg;
        partial_prov_next   = partial_prov_reg;
        received_map_next   = received_map_reg;
        received_total_next = received_total_reg;
        last_valid_next     = last_valid_reg;
        last_seq_next       = last_seq_reg;
        m_tdata_next        = m_tdata_reg;
        err_next            = err_reg;
        m_tvalid_next       = m_tvalid_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            err_next      = rfr_pkg::ERR_OK;
            if (item.clear)
            begin
                partial_open_next   = 1'b0;
                partial_seq_next    = '0;
                partial_prov_next   = '0;
                received_map_next   = '0;
                received_total_next = '0;
                last_valid_next     = 1'b0;
                last_seq_next       = '0;
            end
            else if (err != rfr_pkg::ERR_OK)
            begin
                err_next = err;
            end
            else
            begin
                m_tdata_next[4:0]  = item.slot[rfr_pkg::SLOT_OUT_W-1:0];
                m_tdata_next[5]    = opens;
                m_tdata_next[6]    = done;
                m_tdata_next[38:7] = gap;
                if (done)
                begin
                    last_valid_next     = 1'b1;
                    last_seq_next       = item.seq;
                    partial_open_next   = 1'b0;
                    partial_seq_next    = '0;
                    partial_prov_next   = '0;
                    received_map_next   = '0;
                    received_total_next = '0;
                end
                else
                begin
                    partial_open_next   = 1'b1;
                    partial_seq_next    = item.seq;
                    partial_prov_next   = item.prov;
                    received_map_next   = opens ? one_hot : (received_map_reg | one_hot);
                    received_total_next = total_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_open_reg   <= 1'b0;
            partial_seq_reg    <= '0;
            partial_prov_reg   <= '0;
            received_map_reg   <= '0;
            received_total_reg <= '0;
            last_valid_reg     <= 1'b0;
            last_seq_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            partial_open_reg   <= partial_open_next;
            partial_seq_reg    <= partial_seq_next;
            partial_prov_reg   <= partial_prov_next;
            received_map_reg   <= received_map_next;
            received_total_reg <= received_total_next;
            last_valid_reg     <= last_valid_next;
            last_seq_reg       <= last_seq_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        err_reg     <= err_next;
    end

    `RFR_ASSERT(a_total_matches_map, received_total_reg == TOTAL_W'($countones(received_map_reg)), "received count disagrees with slot map")
    `RFR_ASSERT(a_closed_is_empty, !partial_open_reg |-> (received_map_reg == '0), "closed family holds received slots")
    `RFR_ASSERT(a_total_below_full, received_total_reg < TOTAL_W'(SLOT_COUNT), "received count reached full without completing")
    `RFR_ASSERT_NEXT(a_done_closes, load && !item.clear && (err == rfr_pkg::ERR_OK) && done, !partial_open_reg && last_valid_reg && m_tdata_reg[6], "completion did not close the family")

endmodule

/* rtl/record_family_reassembler_unit.sv */
// Path: an accepted item passes the front register, the queue and the back-end
// output register in that order; the last of them drives m_tvalid.
// Throughput: one item per cycle while m_tready keeps the output free; the family
// state check and update in the back end resolve each item combinationally. A
// two-entry queue decouples the two halves. Reset (rst_n low, asynchronous)
// clears all family state; items are accepted as soon as reset is released.
// ----------------------------------------------------------------------------
// Record family reassembler
// Reassembles measurement chunk families and flags stale, mismatched and
// duplicate chunks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_family_reassembler_unit #(
    parameter int CHANNELS           = 7,
    parameter int CHUNKS_PER_CHANNEL = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sequence_req, channel, chunk_index, generation, sample_rate, sample_total,
    // lane_and_status, first_index, drop_counts, frequency_mhz, metadata_word
    input  logic [rfr_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // record_slot, family_started, completed, lost_families
    output logic [rfr_pkg::M_TDATA_W-1:0] m_tdata,
    // error_code
    output logic [1:0]                    m_tuser
);

    logic           front_valid;
    logic           front_ready;
    rfr_pkg::item_t front_item;
    logic           queue_valid;
    logic           queue_ready;
    rfr_pkg::item_t queue_item;

    rfr_front #(
        .CHANNELS           (CHANNELS),
        .CHUNKS_PER_CHANNEL (CHUNKS_PER_CHANNEL)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    rfr_queue #(
        .DEPTH (rfr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    rfr_back #(
        .CHANNELS           (CHANNELS),
        .CHUNKS_PER_CHANNEL (CHUNKS_PER_CHANNEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* tb/record_family_reassembler_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record family reassembler testbench
// A directed table, then random chunk families with duplicates, provenance
// mismatches, stale sequences, out-of-range channels and clears mixed in.
// Every result is checked against the table's expectation or an in-bench family tracker.
// ----------------------------------------------------------------------------

module record_family_reassembler_unit_test;

    localparam int CHANNELS    = 7;
    localparam int CHUNKS      = 4;
    localparam int SLOTS       = CHANNELS * CHUNKS;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 20;

    // provenance, generation in the lowest bits as on the bus
    typedef struct packed {
        logic [31:0] metadata_word;
        logic [31:0] frequency_mhz;
        logic [63:0] drop_counts;
        logic [63:0] first_index;
        logic [14:0] lane_and_status;
        logic [31:0] sample_total;
        logic [31:0] sample_rate;
        logic [31:0] generation;
    } prov_t;

    typedef struct packed {
        prov_t       prov;
        logic [1:0]  chunk_idx;
        logic [2:0]  channel;
        logic [31:0] seq;
    } chunk_t;

    typedef struct packed {
        rfr_pkg::err_t err;
        logic [31:0]   lost;
        logic          done;
        logic          started;
        logic [4:0]    slot;
    } family_result_t;

    typedef enum logic [1:0] {
        PV_ZERO,
        PV_ONES,
        PV_ALT,
        PV_RAND
    } prov_kind_t;

    typedef struct packed {
        logic          op;
        logic [31:0]   seq;
        logic [2:0]    channel;
        logic [1:0]    chunk_idx;
        prov_kind_t    pkind;
        logic          typed;
        rfr_pkg::err_t exp_err;
        logic [4:0]    exp_slot;
        logic          exp_started;
        logic          exp_done;
        logic [31:0]   exp_lost;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rfr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rfr_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                    m_tuser;

    // family tracker state
    logic        fam_open = 1'b0;
    logic [31:0] fam_seq = '0;
    prov_t       fam_prov = '0;
    logic [SLOTS-1:0] fam_seen = '0;
    int          fam_count = 0;
    logic        done_valid = 1'b0;
    logic [31:0] done_seq = '0;

    family_result_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  tick_count = 0;
    logic quiet = 1'b0;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{rfr_pkg::OP_CLEAR, 32'h0, 3'd0, 2'd0, PV_RAND, 1'b1, rfr_pkg::ERR_OK,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd0, 2'd0, PV_ZERO, 1'b1, rfr_pkg::ERR_OK,
          5'd0, 1'b1, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd0, 2'd0, PV_ZERO, 1'b1, rfr_pkg::ERR_DUPLICATE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd1, 2'd2, PV_ALT, 1'b1, rfr_pkg::ERR_PROVENANCE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd7, 2'd3, PV_ZERO, 1'b1, rfr_pkg::ERR_DUPLICATE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'hFFFF_FFFF, 3'd0, 2'd1, PV_ZERO, 1'b1, rfr_pkg::ERR_STALE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h8000_0000, 3'd0, 2'd1, PV_ZERO, 1'b1, rfr_pkg::ERR_STALE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd6, 2'd3, PV_ZERO, 1'b1, rfr_pkg::ERR_OK,
          5'd27, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd3, 2'd1, PV_ZERO, 1'b1, rfr_pkg::ERR_OK,
          5'd13, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h7FFF_FFFF, 3'd2, 2'd0, PV_ONES, 1'b1, rfr_pkg::ERR_OK,
          5'd8, 1'b1, 1'b0, 32'h7FFF_FFFF},
        '{rfr_pkg::OP_CHUNK, 32'h7FFF_FFFF, 3'd2, 2'd0, PV_ONES, 1'b1, rfr_pkg::ERR_DUPLICATE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h7FFF_FFFF, 3'd0, 2'd0, PV_ZERO, 1'b1, rfr_pkg::ERR_PROVENANCE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h7FFF_FFFF, 3'd6, 2'd3, PV_ONES, 1'b1, rfr_pkg::ERR_OK,
          5'd27, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h0, 3'd1, 2'd1, PV_ONES, 1'b1, rfr_pkg::ERR_STALE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CLEAR, 32'hFFFF_FFFF, 3'd7, 2'd3, PV_ONES, 1'b1, rfr_pkg::ERR_OK,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'hFFFF_FFFF, 3'd7, 2'd3, PV_ONES, 1'b1, rfr_pkg::ERR_DUPLICATE,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'hFFFF_FFFF, 3'd0, 2'd0, PV_RAND, 1'b1, rfr_pkg::ERR_OK,
          5'd0, 1'b1, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h5, 3'd1, 2'd1, PV_RAND, 1'b1, rfr_pkg::ERR_OK,
          5'd5, 1'b1, 1'b0, 32'h6},
        '{rfr_pkg::OP_CHUNK, 32'h5, 3'd1, 2'd2, PV_RAND, 1'b0, rfr_pkg::ERR_OK,
          5'd0, 1'b0, 1'b0, 32'h0},
        '{rfr_pkg::OP_CHUNK, 32'h5, 3'd4, 2'd3, PV_RAND, 1'b0, rfr_pkg::ERR_OK,
          5'd0, 1'b0, 1'b0, 32'h0}
    };

    record_family_reassembler_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic logic seq_ahead(input logic [31:0] cand, input logic [31:0] base);
        logic [31:0] d;
        d = cand - base;
        return (d != 32'h0) && (d < 32'h8000_0000);
    endfunction

    function automatic prov_t rand_prov();
        prov_t p;
        p.generation      = $urandom;
        p.sample_rate     = $urandom;
        p.sample_total    = $urandom;
        p.lane_and_status = 15'($urandom);
        p.first_index     = {$urandom, $urandom};
        p.drop_counts     = {$urandom, $urandom};
        p.frequency_mhz   = $urandom;
        p.metadata_word   = $urandom;
        return p;
    endfunction

    // Advances the family tracker by one item and returns the result it yields.
    function automatic family_result_t predict_chunk(input logic op, input chunk_t c);
        family_result_t r;
        logic           opens;
        logic [31:0]    gap;
        int unsigned    slot_n;
        r = '0;
        opens = 1'b0;
        gap = '0;
        slot_n = 0;
        if (op == rfr_pkg::OP_CLEAR)
        begin
            fam_open = 1'b0;
            fam_seq = '0;
            fam_prov = '0;
            fam_seen = '0;
            fam_count = 0;
            done_valid = 1'b0;
            done_seq = '0;
            return r;
        end
        if (fam_open && c.seq != fam_seq)
        begin
            if (!seq_ahead(c.seq, fam_seq))
                r.err = rfr_pkg::ERR_STALE;
            else
            begin
                gap = c.seq - fam_seq;
                opens = 1'b1;
            end
        end
        else if (!fam_open)
        begin
            opens = 1'b1;
            if (done_valid)
            begin
                if (!seq_ahead(c.seq, done_seq))
                    r.err = rfr_pkg::ERR_STALE;
                else
                    gap = c.seq - (done_seq + 32'd1);
            end
        end
        if (r.err == rfr_pkg::ERR_OK && !opens && c.prov != fam_prov)
            r.err = rfr_pkg::ERR_PROVENANCE;
        if (r.err == rfr_pkg::ERR_OK)
        begin
            // an out-of-range slot counts as a duplicate, even on an opening chunk
            if (c.channel >= CHANNELS || c.chunk_idx >= CHUNKS)
                r.err = rfr_pkg::ERR_DUPLICATE;
            else
            begin
                slot_n = c.channel * CHUNKS + c.chunk_idx;
                if (!opens && fam_seen[slot_n])
                    r.err = rfr_pkg::ERR_DUPLICATE;
            end
        end
        if (r.err != rfr_pkg::ERR_OK)
            return r;
        if (opens)
        begin
            fam_open = 1'b1;
            fam_seq = c.seq;
            fam_prov = c.prov;
            fam_seen = '0;
            fam_count = 0;
        end
        fam_seen[slot_n] = 1'b1;
        fam_count++;
        r.slot = slot_n[4:0];
        r.started = opens;
        r.lost = gap;
        if (fam_count >= SLOTS)
        begin
            r.done = 1'b1;
            done_valid = 1'b1;
            done_seq = c.seq;
            fam_open = 1'b0;
            fam_seq = '0;
            fam_prov = '0;
            fam_seen = '0;
            fam_count = 0;
        end
        return r;
    endfunction

    // Drives one item, waits for its handshake and queues its expected result.
    task automatic send_chunk(input logic op, input chunk_t c, input logic typed,
                              input family_result_t typed_res);
        family_result_t pred;
        pred = predict_chunk(op, c);
        while (!quiet && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(rfr_pkg::S_TDATA_W - $bits(chunk_t)){1'b0}}, c};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99) >= 14);
    end

    always @(posedge clk)
    begin
        family_result_t got;
        family_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.err     = rfr_pkg::err_t'(m_tuser);
            got.slot    = m_tdata[4:0];
            got.started = m_tdata[5];
            got.done    = m_tdata[6];
            got.lost    = m_tdata[38:7];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.err != exp.err || got.slot != exp.slot || got.started != exp.started ||
                    got.done != exp.done || got.lost != exp.lost)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected err=%0d slot=%0d started=%0b done=%0b",
                                 results_seen, exp.err, exp.slot, exp.started, exp.done,
                                 " lost=%08h, got err=%0d slot=%0d started=%0b done=%0b",
                                 exp.lost, got.err, got.slot, got.started, got.done,
                                 " lost=%08h", got.lost);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        tick_count++;
        if (tick_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        chunk_t         c;
        family_result_t tr;
        logic [302:0]   pbits;
        logic [31:0]    anchor;
        logic [31:0]    gen_seq;
        prov_t          gen_prov;
        int             order [SLOTS];
        int             pos;
        int             stop_at;
        int             pick;
        int             j;
        int             tmp;
        int             sent;
        logic           has_family;
        logic           op;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            c.seq = dir_rows[i].seq;
            c.channel = dir_rows[i].channel;
            c.chunk_idx = dir_rows[i].chunk_idx;
            case (dir_rows[i].pkind)
                PV_ZERO: c.prov = '0;
                PV_ONES: c.prov = '1;
                PV_ALT:  c.prov = {101{3'b101}};
                default: c.prov = rand_prov();
            endcase
            // the last two rows reuse the open family's provenance, the first
            // of them with a flipped generation
            if (i == 18 || i == 19)
                c.prov = fam_prov;
            if (i == 18)
                c.prov.generation = ~c.prov.generation;
            tr.err = dir_rows[i].exp_err;
            tr.slot = dir_rows[i].exp_slot;
            tr.started = dir_rows[i].exp_started;
            tr.done = dir_rows[i].exp_done;
            tr.lost = dir_rows[i].exp_lost;
            send_chunk(dir_rows[i].op, c, dir_rows[i].typed, tr);
        end

        has_family = 1'b0;
        pos = 0;
        stop_at = SLOTS;
        gen_seq = '0;
        gen_prov = '0;
        sent = 0;
        tr = '0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (sent >= 250 && sent < 400);
            if (!has_family)
            begin
                if (fam_open)
                    anchor = fam_seq;
                else if (done_valid)
                    anchor = done_seq;
                else
                    anchor = $urandom;
                pick = $urandom_range(99);
                if (pick < 70)
                    gen_seq = anchor + $urandom_range(1, 3);
                else if (pick < 90)
                    gen_seq = anchor + $urandom_range(1, 1000);
                else
                    gen_seq = anchor + $urandom_range(1, 32'h7FFF_FFFF);
                gen_prov = rand_prov();
                for (int i = 0; i < SLOTS; i++)
                    order[i] = i;
                for (int i = SLOTS - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                pos = 0;
                stop_at = ($urandom_range(99) < 25) ? $urandom_range(1, SLOTS - 1) : SLOTS;
                has_family = 1'b1;
            end

            op = rfr_pkg::OP_CHUNK;
            c.seq = gen_seq;
            c.prov = gen_prov;
            c.channel = 3'(order[pos] / CHUNKS);
            c.chunk_idx = 2'(order[pos] % CHUNKS);
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                op = rfr_pkg::OP_CLEAR;
                c.seq = $urandom;
                c.prov = rand_prov();
                has_family = 1'b0;
            end
            else if (pick < 8 && pos > 0)
            begin
                j = order[$urandom_range(0, pos - 1)];
                c.channel = 3'(j / CHUNKS);
                c.chunk_idx = 2'(j % CHUNKS);
            end
            else if (pick < 13 && pos > 0)
            begin
                pbits = gen_prov;
                j = $urandom_range(0, 302);
                pbits[j] = ~pbits[j];
                c.prov = pbits;
            end
            else if (pick < 16 && (fam_open || done_valid))
            begin
                anchor = fam_open ? fam_seq : done_seq;
                c.seq = anchor + $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            end
            else if (pick < 19)
            begin
                c.channel = 3'd7;
                c.chunk_idx = 2'($urandom_range(0, 3));
            end
            else
            begin
                pos++;
                if (pos >= stop_at)
                    has_family = 1'b0;
            end
            send_chunk(op, c, 1'b0, tr);
            sent++;
        end

        s_tvalid <= 1'b0;
        quiet = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
